// ----- hw/rtl/cdq_pkg.sv -----
// Shared types and constants for the circular deque.
`timescale 1ns / 1ps

package cdq_pkg;

    localparam int WORD_W = 32;
    localparam int OCC_W  = 4;

    typedef enum logic [1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_PUSH_REAR  = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_REAR   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;       // accept the input item: update indices, write or read the store
        logic load_now;   // load the result register from the push result
        logic load_pend;  // load the result register from the pending pop result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_pop;
    } t_sts;

endpackage

// ----- hw/rtl/cdq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/cdq_ctrl.sv -----
// Controller for the circular deque: handshakes and pop read sequencing.
`timescale 1ns / 1ps

module cdq_ctrl
    import cdq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   take;

    // Accept when idle and the result register is free or drains this cycle.
    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign take       = i_in_valid && o_in_ready;

    always_comb begin
        n_state        = r_state;
        o_cmd.take      = 1'b0;
        o_cmd.load_now  = 1'b0;
        o_cmd.load_pend = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    o_cmd.take = 1'b1;
                    if (i_sts.is_pop) begin
                        n_state = S_READ;
                    end else begin
                        o_cmd.load_now = 1'b1;
                    end
                end
            end
            S_READ: begin
                o_cmd.load_pend = 1'b1;
                n_state         = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        priority if (o_cmd.load_now || o_cmd.load_pend) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- hw/rtl/cdq_datapath.sv -----
// Datapath for the circular deque: indices, count, word store, result register.
`timescale 1ns / 1ps

module cdq_datapath
    import cdq_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic [1:0]        i_mode,
    input  logic [WORD_W-1:0] i_push_word,
    output logic [WORD_W-1:0] o_pop_word,
    output logic [1:0]        o_status,
    output logic [OCC_W-1:0]  o_occupancy
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_mode mode;

    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;

    logic [AW-1:0] head_next, head_prev, tail_next, tail_prev;
    logic          full, empty;
    t_status       res_status;
    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    logic [WORD_W-1:0] rdata;
    logic [CW+OCC_W-1:0] occ_wide;

    t_status          r_pend_status;
    logic [OCC_W-1:0] r_pend_occ;
    logic             r_pend_ok;

    logic [WORD_W-1:0] r_pop_word;
    t_status           r_status;
    logic [OCC_W-1:0]  r_occ;

    assign mode         = t_mode'(i_mode);
    assign o_sts.is_pop = (mode == MODE_POP_FRONT) || (mode == MODE_POP_REAR);

    assign head_next = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
    assign head_prev = (r_head == '0) ? LAST_IDX : r_head - 1'b1;
    assign tail_next = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;
    assign tail_prev = (r_tail == '0) ? LAST_IDX : r_tail - 1'b1;

    assign full  = (r_count == FULL_CNT);
    assign empty = (r_count == '0);

    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        res_status = ST_DONE;
        we         = 1'b0;
        re         = 1'b0;
        waddr      = '0;
        raddr      = '0;
        unique case (mode)
            MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
                if (full) begin
                    res_status = ST_OVERFLOW;
                end else begin
                    we      = 1'b1;
                    n_count = r_count + 1'b1;
                    priority if (empty) begin
                        // First word always lands in slot zero.
                        n_head = '0;
                        n_tail = '0;
                        waddr  = '0;
                    end else if (mode == MODE_PUSH_FRONT) begin
                        n_head = head_prev;
                        waddr  = head_prev;
                    end else begin
                        n_tail = tail_next;
                        waddr  = tail_next;
                    end
                end
            end
            MODE_POP_FRONT, MODE_POP_REAR: begin
                if (empty) begin
                    res_status = ST_UNDERFLOW;
                end else begin
                    re      = 1'b1;
                    n_count = r_count - 1'b1;
                    if (mode == MODE_POP_FRONT) begin
                        raddr = r_head;
                        // Last word out: keep the indices as they are.
                        if (r_count != CW'(1)) begin
                            n_head = head_next;
                        end
                    end else begin
                        raddr = r_tail;
                        if (r_count != CW'(1)) begin
                            n_tail = tail_prev;
                        end
                    end
                end
            end
            default: res_status = ST_DONE;
        endcase
    end

    // Report the count modulo the field width.
    assign occ_wide = {{OCC_W{1'b0}}, n_count};

    cdq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.take && we),
        .i_waddr (waddr),
        .i_wdata (i_push_word),
        .i_re    (i_cmd.take && re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_cmd.take) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_pend_status <= res_status;
            r_pend_occ    <= occ_wide[OCC_W-1:0];
            r_pend_ok     <= re;
        end
        priority if (i_cmd.load_now) begin
            r_pop_word <= '0;
            r_status   <= res_status;
            r_occ      <= occ_wide[OCC_W-1:0];
        end else if (i_cmd.load_pend) begin
            r_pop_word <= r_pend_ok ? rdata : '0;
            r_status   <= r_pend_status;
            r_occ      <= r_pend_occ;
        end else begin
            r_pop_word <= r_pop_word;
            r_status   <= r_status;
            r_occ      <= r_occ;
        end
    end

    assign o_pop_word  = r_pop_word;
    assign o_status    = r_status;
    assign o_occupancy = r_occ;

endmodule

// ----- hw/rtl/circular_deque_top.sv -----
// Top level of the circular deque: controller, datapath and assertions.
// A push result is registered straight into the result register; a pop result
// passes through the registered read port of the word store, then the result register.
// Pushes are taken at one per cycle while the result register is free or drains; a pop
// holds off the next item during its read state.
// Reset: synchronous, active low; clears indices, count and result valid.
// Store contents stay undefined after reset; no clearing pass is run.
`timescale 1ns / 1ps

module circular_deque_top
    import cdq_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_mode,
    input  logic signed [WORD_W-1:0] i_push_word,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic signed [WORD_W-1:0] o_pop_word,
    output logic [1:0]        o_status,
    output logic [OCC_W-1:0]  o_occupancy
);

    t_cmd cmd;
    t_sts sts;

    cdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    cdq_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_mode      (i_mode),
        .i_push_word (i_push_word),
        .o_pop_word  (o_pop_word),
        .o_status    (o_status),
        .o_occupancy (o_occupancy)
    );

    // A stalled result blocks the next item.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("item accepted while result stalled");

    // A pop holds off the next item during its read state.
    a_pop_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.take && sts.is_pop) |=> (!o_in_ready && cmd.load_pend))
        else $error("pop read cycle missing");

    // A refused operation returns a zero word.
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_OVERFLOW || o_status == ST_UNDERFLOW))
        |-> (o_pop_word == '0))
        else $error("refused operation returned a word");

    // Underflow happens only on an empty store, which stays empty.
    a_underflow_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_UNDERFLOW) |-> (o_occupancy == '0))
        else $error("underflow with nonzero occupancy");

endmodule

// ----- test/circular_deque_top_test.sv -----
// Self-checking circular deque testbench: directed and random ops against a deque model.
`timescale 1ns / 1ps

module circular_deque_top_test;
    import cdq_pkg::*;

    localparam int DEPTH       = 8;
    localparam int QUIET_TAIL  = 150;
    localparam int LONG_HOLD   = 80;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        t_mode                    mode;
        logic signed [WORD_W-1:0] word;
        bit                       drain;
    } t_op_item;

    typedef struct {
        logic signed [WORD_W-1:0] pop_word;
        t_status                  status;
        logic [OCC_W-1:0]         occupancy;
    } t_deque_result;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     in_valid    = 1'b0;
    t_mode                    in_mode     = MODE_PUSH_FRONT;
    logic signed [WORD_W-1:0] in_word     = '0;
    logic                     out_ready   = 1'b0;
    logic                     o_in_ready;
    logic                     o_out_valid;
    logic signed [WORD_W-1:0] o_pop_word;
    logic [1:0]               o_status;
    logic [OCC_W-1:0]         o_occupancy;

    t_op_item      pending_ops[$];
    t_deque_result expected_results[$];

    // Model of the deque contents
    logic signed [WORD_W-1:0] dq_store [DEPTH];
    int                       dq_head  = 0;
    int                       dq_tail  = 0;
    bit                       dq_empty = 1'b1;

    int items_sent   = 0;
    int total_items  = 32'h7fff_ffff;
    int fail_count   = 0;
    int send_gap     = 0;
    int stall_left   = 0;
    int long_hold    = 0;
    int holds_done   = 0;
    int idle_cycles  = 0;
    bit quiet;

    assign quiet = (items_sent >= total_items - QUIET_TAIL);

    circular_deque_top #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (in_mode),
        .i_push_word (in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_pop_word  (o_pop_word),
        .o_status    (o_status),
        .o_occupancy (o_occupancy)
    );

    always #1 i_clk = ~i_clk;

    function automatic int next_idx(input int idx);
        return (idx + 1 >= DEPTH) ? 0 : idx + 1;
    endfunction

    function automatic int prev_idx(input int idx);
        return (idx == 0) ? DEPTH - 1 : idx - 1;
    endfunction

    function automatic t_deque_result deque_apply(input t_mode op,
                                                  input logic signed [WORD_W-1:0] word);
        t_deque_result r;
        r.pop_word = '0;
        r.status   = ST_DONE;
        if (op == MODE_PUSH_FRONT || op == MODE_PUSH_REAR) begin
            if (!dq_empty && next_idx(dq_tail) == dq_head) begin
                r.status = ST_OVERFLOW;
            end else if (dq_empty) begin
                // first word always lands in slot zero
                dq_head     = 0;
                dq_tail     = 0;
                dq_empty    = 1'b0;
                dq_store[0] = word;
            end else if (op == MODE_PUSH_FRONT) begin
                dq_head           = prev_idx(dq_head);
                dq_store[dq_head] = word;
            end else begin
                dq_tail           = next_idx(dq_tail);
                dq_store[dq_tail] = word;
            end
        end else if (dq_empty) begin
            r.status = ST_UNDERFLOW;
        end else if (op == MODE_POP_FRONT) begin
            r.pop_word = dq_store[dq_head];
            if (dq_head == dq_tail) dq_empty = 1'b1;
            else dq_head = next_idx(dq_head);
        end else begin
            r.pop_word = dq_store[dq_tail];
            if (dq_head == dq_tail) dq_empty = 1'b1;
            else dq_tail = prev_idx(dq_tail);
        end
        r.occupancy = dq_empty ? '0 : OCC_W'((dq_tail - dq_head + DEPTH) % DEPTH + 1);
        return r;
    endfunction

    task automatic queue_op(input t_mode m, input logic [WORD_W-1:0] w, input bit drain);
        t_op_item it;
        it.mode  = m;
        it.word  = w;
        it.drain = drain;
        pending_ops.push_back(it);
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Sender: hold valid and payload until the item is taken
    always @(posedge i_clk) begin : drive_proc
        bit                       fire;
        bit                       nxt_valid;
        t_mode                    nxt_mode;
        logic signed [WORD_W-1:0] nxt_word;
        int                       nxt_gap;
        fire      = in_valid && o_in_ready;
        nxt_valid = in_valid;
        nxt_mode  = in_mode;
        nxt_word  = in_word;
        nxt_gap   = send_gap;
        if (i_rst_n) begin
            if (fire) begin
                expected_results.push_back(deque_apply(in_mode, in_word));
                items_sent <= items_sent + 1;
            end
            if (!in_valid || fire) begin
                nxt_valid = 1'b0;
                if (send_gap > 0) begin
                    nxt_gap = send_gap - 1;
                end else if (pending_ops.size() != 0) begin
                    if (pending_ops[0].drain && (fire || expected_results.size() != 0)) begin
                        // wait for every result before this item
                    end else if (!quiet && long_hold == 0 && ((items_sent / 64) % 3 != 2)
                                 && $urandom_range(0, 4) == 0) begin
                        nxt_gap = $urandom_range(0, 7);
                    end else begin
                        nxt_valid = 1'b1;
                        nxt_mode  = pending_ops[0].mode;
                        nxt_word  = pending_ops[0].word;
                        void'(pending_ops.pop_front());
                    end
                end
            end
        end
        in_valid <= nxt_valid;
        in_mode  <= nxt_mode;
        in_word  <= nxt_word;
        send_gap <= nxt_gap;
    end

    // Receiver: random stall bursts plus two long hold-offs to back up the block
    always @(posedge i_clk) begin : recv_proc
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (long_hold != 0) begin
            out_ready <= 1'b0;
            long_hold <= long_hold - 1;
        end else if ((holds_done == 0 && items_sent >= 300)
                     || (holds_done == 1 && items_sent >= 800)) begin
            out_ready  <= 1'b0;
            long_hold  <= LONG_HOLD - 1;
            holds_done <= holds_done + 1;
        end else if (stall_left != 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!quiet && ((items_sent / 50) % 4 != 3) && $urandom_range(0, 5) == 0) begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 7);
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Monitor: compare each taken result with the oldest expectation
    always @(posedge i_clk) begin : check_proc
        t_deque_result exp_r;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                fail_count = fail_count + 1;
                if (fail_count <= MAX_REPORTS)
                    $display("ERROR: result with nothing expected: word %0d status %0d occ %0d",
                             o_pop_word, o_status, o_occupancy);
            end else begin
                exp_r = expected_results.pop_front();
                if (o_pop_word !== exp_r.pop_word || o_status !== exp_r.status
                    || o_occupancy !== exp_r.occupancy) begin
                    fail_count = fail_count + 1;
                    if (fail_count <= MAX_REPORTS)
                        $display({"ERROR: word exp %0d got %0d, ",
                                  "status exp %0d got %0d, occ exp %0d got %0d"},
                                 exp_r.pop_word, o_pop_word, exp_r.status, o_status,
                                 exp_r.occupancy, o_occupancy);
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog_proc
        if (!i_rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL circular_deque_top");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stim_proc
        int push_pct;
        bit is_push;
        // Underflow on both ends of an empty deque; push word is ignored
        queue_op(MODE_POP_FRONT, 32'hffff_ffff, 1'b0);
        queue_op(MODE_POP_REAR,  32'ha5a5_a5a5, 1'b0);
        // Push onto empty from the rear, then pop the last word
        queue_op(MODE_PUSH_REAR, 32'h7fff_ffff, 1'b0);
        queue_op(MODE_POP_REAR,  32'h0000_0000, 1'b0);
        // Fill from both ends; the head index wraps from slot zero to the last slot
        queue_op(MODE_PUSH_FRONT, 32'h8000_0000, 1'b0);
        queue_op(MODE_PUSH_FRONT, 32'hffff_ffff, 1'b0);
        queue_op(MODE_PUSH_FRONT, 32'h0000_0000, 1'b0);
        queue_op(MODE_PUSH_REAR,  32'h5555_5555, 1'b0);
        queue_op(MODE_PUSH_FRONT, 32'haaaa_aaaa, 1'b0);
        queue_op(MODE_PUSH_REAR,  32'h7fff_ffff, 1'b0);
        queue_op(MODE_PUSH_REAR,  32'h1234_5678, 1'b0);
        queue_op(MODE_PUSH_FRONT, 32'hfedc_ba98, 1'b0);
        // Overflow on a full deque from either end
        queue_op(MODE_PUSH_FRONT, 32'hdead_beef, 1'b0);
        queue_op(MODE_PUSH_REAR,  32'h0bad_f00d, 1'b0);
        // Drain from both ends, then underflow once more
        queue_op(MODE_POP_FRONT, 32'h0000_0000, 1'b0);
        queue_op(MODE_POP_REAR,  32'hffff_ffff, 1'b0);
        queue_op(MODE_POP_FRONT, 32'h0000_0000, 1'b0);
        queue_op(MODE_POP_REAR,  32'h0000_0000, 1'b0);
        queue_op(MODE_POP_REAR,  32'h0000_0000, 1'b0);
        queue_op(MODE_POP_FRONT, 32'h0000_0000, 1'b0);
        queue_op(MODE_POP_FRONT, 32'h0000_0000, 1'b0);
        queue_op(MODE_POP_REAR,  32'h0000_0000, 1'b0);
        queue_op(MODE_POP_FRONT, 32'h5a5a_5a5a, 1'b0);

        // Random part: chunks biased toward filling, draining or wandering
        for (int chunk = 0; chunk < 30; chunk++) begin
            case ($urandom_range(0, 2))
                0: push_pct = 20;
                1: push_pct = 50;
                default: push_pct = 80;
            endcase
            for (int k = 0; k < 40; k++) begin
                is_push = ($urandom_range(0, 99) < push_pct);
                queue_op(is_push ? t_mode'($urandom_range(0, 1)) : t_mode'($urandom_range(2, 3)),
                         pick_word(), (k == 0) && (chunk == 0 || chunk == 15));
            end
        end
        total_items = pending_ops.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_ops.size() != 0 || in_valid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("PASS circular_deque_top");
        end else begin
            $display("FAIL circular_deque_top");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/cdq_pkg.sv
hw/rtl/cdq_ram.sv
hw/rtl/cdq_ctrl.sv
hw/rtl/cdq_datapath.sv
hw/rtl/circular_deque_top.sv
test/circular_deque_top_test.sv
